@@ design/dtet_pkg.sv @@
// ----------------------------------------------------------------------------
// dtet_pkg
// Shared constants, command codes and pipeline control types for the
// dihedral trigonometric energy term unit.
// ----------------------------------------------------------------------------
package dtet_pkg;

  localparam int NumPairTypesDef  = 16;
  localparam int AngleFracBitsDef = 13;

  localparam int NCOEF   = 6;
  localparam int COEF_W  = 32;
  localparam int ANG_W   = 16;
  localparam int TRIG_W  = 18;
  localparam int OUT_W   = 40;

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  localparam int RECIP_W = 12;
  localparam int QUOT_W  = 8;

  localparam int SIN_N = 5;
  localparam int COS_N = 6;
  localparam int unsigned SIN_DIV [SIN_N] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_N] = '{132, 90, 56, 30, 12, 2};

  localparam int HORNER_LAT = 3;
  localparam int SC_LAT     = 7 + COS_N * HORNER_LAT + 1;
  localparam int E_LAT      = 6;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } dtet_cmd_e;

  typedef struct packed {
    logic vld;
    logic eval;
    logic in_rng;
  } dtet_ctl_t;

endpackage

@@ design/dihedral_trig_energy_term_unit.sv @@
// ----------------------------------------------------------------------------
// dihedral_trig_energy_term_unit
// A request passes 26 sine/cosine stages, 1 table read stage, 6 energy stages
// and the output register before its result appears on out_valid_o.
// One request per cycle unless a stalled output holds the pipeline; loads write the
// coefficient table at the read stage, in request order. Reset clears all valid bits; table undefined.
// ----------------------------------------------------------------------------
module dihedral_trig_energy_term_unit
  import dtet_pkg::*;
#(
  parameter int NUM_PAIR_TYPES  = NumPairTypesDef,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    cmd_i,
  input  logic [3:0]              pair_type_i,
  input  logic [2:0]              coeff_slot_i,
  input  logic signed [COEF_W-1:0] coeff_value_i,
  input  logic signed [ANG_W-1:0] angle_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] energy_o,
  output logic signed [OUT_W-1:0] energy_slope_o
);

  localparam int AW  = $clog2(NUM_PAIR_TYPES);
  localparam int PtW = (AW > 4) ? AW : 4;

  dtet_ctl_t          ctl_q [SC_LAT];
  logic [AW-1:0]      idx_q [SC_LAT];
  logic [2:0]         slot_q [SC_LAT];
  logic [COEF_W-1:0]  val_q [SC_LAT];
  logic [E_LAT:0]     bvld_q;
  logic               m_rng_q;
  logic               out_valid_q;
  logic signed [OUT_W-1:0] energy_q, slope_q;

  logic [NCOEF-1:0][COEF_W-1:0] mem [NUM_PAIR_TYPES];
  logic [NCOEF-1:0][COEF_W-1:0] rd_q;
  logic signed [TRIG_W-1:0] s_m_q, c_m_q;

  logic                     adv, acc, tail, wr_en, rd_en;
  logic [PtW-1:0]           pt_ext;
  dtet_ctl_t                ctl_d, ctl_m;
  logic signed [TRIG_W-1:0] sin_w, cos_w;
  logic [NCOEF-1:0][COEF_W-1:0] coef;
  logic signed [OUT_W-1:0]  e_w, sl_w;

  always_comb begin
    tail       = bvld_q[E_LAT];
    adv        = !(tail && out_valid_q && out_stall_i);
    acc        = in_valid_i && adv;
    pt_ext     = PtW'(pair_type_i);
    ctl_d.vld    = acc;
    ctl_d.eval   = (cmd_i == CMD_EVAL);
    ctl_d.in_rng = (32'(pair_type_i) < 32'(NUM_PAIR_TYPES));
    ctl_m      = ctl_q[SC_LAT-1];
    wr_en      = adv && ctl_m.vld && !ctl_m.eval && ctl_m.in_rng &&
                 (slot_q[SC_LAT-1] < 3'(NCOEF));
    rd_en      = adv && ctl_m.vld && ctl_m.eval && ctl_m.in_rng;
    coef       = m_rng_q ? rd_q : '0;
  end

  dtet_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sincos (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (angle_i),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  dtet_energy u_energy (
    .clk_i          (clk_i),
    .en_i           (adv),
    .sin_i          (s_m_q),
    .cos_i          (c_m_q),
    .coef_i         (coef),
    .energy_o       (e_w),
    .energy_slope_o (sl_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SC_LAT; i++) ctl_q[i] <= '0;
      bvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        ctl_q[0] <= ctl_d;
        for (int i = 1; i < SC_LAT; i++) ctl_q[i] <= ctl_q[i-1];
        bvld_q <= {bvld_q[E_LAT-1:0], ctl_m.vld && ctl_m.eval};
      end
      if (tail && adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx_q[0]  <= pt_ext[AW-1:0];
      slot_q[0] <= coeff_slot_i;
      val_q[0]  <= coeff_value_i;
      for (int i = 1; i < SC_LAT; i++) begin
        idx_q[i]  <= idx_q[i-1];
        slot_q[i] <= slot_q[i-1];
        val_q[i]  <= val_q[i-1];
      end
      s_m_q   <= sin_w;
      c_m_q   <= cos_w;
      m_rng_q <= rd_en;
    end
    if (tail && adv) begin
      energy_q <= e_w;
      slope_q  <= sl_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q[SC_LAT-1]][slot_q[SC_LAT-1]] <= val_q[SC_LAT-1];
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[SC_LAT-1]];
    end
  end

  assign in_stall_o     = !adv;
  assign out_valid_o    = out_valid_q;
  assign energy_o       = energy_q;
  assign energy_slope_o = slope_q;

  a_hold_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail && out_valid_q && out_stall_i |=> bvld_q[E_LAT] && out_valid_q)
    else $error("pipeline tail lost while output stalled");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(bvld_q[E_LAT]))
    else $error("result without pipeline tail");

  a_eval_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_EVAL |=> ctl_q[0].vld && ctl_q[0].eval)
    else $error("accepted evaluate request not in pipeline");

  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("table read and write in same cycle");

endmodule

@@ design/dtet_horner_step.sv @@
// ----------------------------------------------------------------------------
// dtet_horner_step
// One Horner step t' = 1 - ((z * t) >> 30) / DIV in Q30, three stages:
// product, reciprocal multiply, quotient correction.
// ----------------------------------------------------------------------------
module dtet_horner_step
  import dtet_pkg::*;
#(
  parameter int unsigned DIV = 2
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] z_i,
  input  logic [30:0] t_i,
  output logic [31:0] z_o,
  output logic [30:0] t_o
);

  localparam longint unsigned RecipL = (64'd1 << 32) / DIV;
  localparam logic [31:0]     Recip  = RecipL[31:0];
  localparam logic [7:0]      DivC   = 8'(DIV);

  logic [31:0] za_q, zb_q, zc_q;
  logic [31:0] wa_q, wb_q, qb_q;
  logic [30:0] t_q;

  logic [62:0] prod_a;
  logic [63:0] prod_b;
  logic [39:0] qd;
  logic [39:0] rem;
  logic [31:0] qf;
  logic [31:0] tn;

  always_comb begin
    prod_a = {31'd0, z_i} * {32'd0, t_i};
    prod_b = {32'd0, wa_q} * {32'd0, Recip};
    qd     = {8'd0, qb_q} * {32'd0, DivC};
    rem    = {8'd0, wb_q} - qd;
    qf     = qb_q + ((rem >= 40'(DIV)) ? 32'd1 : 32'd0);
    tn     = {1'b0, Q30_ONE} - qf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wa_q <= prod_a[61:30];
      za_q <= z_i;
      wb_q <= wa_q;
      qb_q <= prod_b[63:32];
      zb_q <= za_q;
      t_q  <= tn[30:0];
      zc_q <= zb_q;
    end
  end

  assign z_o = zc_q;
  assign t_o = t_q;

endmodule

@@ design/dtet_sincos.sv @@
// ----------------------------------------------------------------------------
// dtet_sincos
// Pipelined sine and cosine: range reduction modulo two pi, quadrant fold,
// parallel Horner chains, Q16 rounding. One angle per enabled cycle.
// ----------------------------------------------------------------------------
module dtet_sincos
  import dtet_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [ANG_W-1:0]  angle_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam int Shift = 30 - ANGLE_FRAC_BITS;
  localparam longint unsigned RecipL = (64'd1 << (Shift + 20)) / 64'(TWO_PI_Q30);
  localparam logic [RECIP_W-1:0] Recip = RecipL[RECIP_W-1:0];
  localparam int PW     = QUOT_W + 33;
  localparam int SinDl  = SIN_N * HORNER_LAT;
  localparam int CosDl  = COS_N * HORNER_LAT;
  localparam int SinPad = CosDl - SinDl - 1;

  logic [ANG_W-1:0]  a0_q, a1_q;
  logic              n0_q, n1_q, n2_q, n3_q, n4_q;
  logic [QUOT_W-1:0] q1_q;
  logic [33:0]       r2_q;
  logic [32:0]       r3_q;
  logic [31:0]       m4_q;
  logic [30:0]       u5_q, u6_q;
  logic              sn5_q, cn5_q;
  logic [31:0]       z6_q;
  logic [1:0]        sg6_q;
  logic [1:0]        sg_dl_q [CosDl];
  logic [30:0]       u_dl_q [SinDl];
  logic [30:0]       sm_dl_q [SinPad+1];
  logic signed [TRIG_W-1:0] sin_q, cos_q;

  logic [ANG_W-1:0]  a_abs;
  logic [27:0]       prod1;
  logic [PW-1:0]     xs, qt, r0;
  logic [33:0]       r3_d;
  logic [61:0]       zp;
  logic [61:0]       sp;
  logic [30:0]       s_cl, c_cl;
  logic [30:0]       s_rd, c_rd;
  logic [TRIG_W-1:0] s_mag, c_mag;

  logic [31:0] sin_z [SIN_N+1];
  logic [30:0] sin_t [SIN_N+1];
  logic [31:0] cos_z [COS_N+1];
  logic [30:0] cos_t [COS_N+1];

  assign sin_z[0] = z6_q;
  assign sin_t[0] = Q30_ONE;
  assign cos_z[0] = z6_q;
  assign cos_t[0] = Q30_ONE;

  for (genvar g = 0; g < SIN_N; g++) begin : g_sin
    dtet_horner_step #(.DIV(SIN_DIV[g])) u_step (
      .clk_i (clk_i),
      .en_i  (en_i),
      .z_i   (sin_z[g]),
      .t_i   (sin_t[g]),
      .z_o   (sin_z[g+1]),
      .t_o   (sin_t[g+1])
    );
  end

  for (genvar g = 0; g < COS_N; g++) begin : g_cos
    dtet_horner_step #(.DIV(COS_DIV[g])) u_step (
      .clk_i (clk_i),
      .en_i  (en_i),
      .z_i   (cos_z[g]),
      .t_i   (cos_t[g]),
      .z_o   (cos_z[g+1]),
      .t_o   (cos_t[g+1])
    );
  end

  always_comb begin
    a_abs = angle_i[ANG_W-1] ? (~angle_i + 16'd1) : angle_i;
    prod1 = {12'd0, a0_q} * {16'd0, Recip};
    xs    = PW'(a1_q) << Shift;
    qt    = {33'd0, q1_q} * {8'd0, TWO_PI_Q30};
    r0    = xs - qt;
    r3_d  = r2_q - {1'b0, TWO_PI_Q30};
    zp    = {31'd0, u5_q} * {31'd0, u5_q};
    sp    = {31'd0, u_dl_q[SinDl-1]} * {31'd0, sin_t[SIN_N]};
    s_cl  = (sm_dl_q[SinPad] > Q30_ONE) ? Q30_ONE : sm_dl_q[SinPad];
    c_cl  = (cos_t[COS_N] > Q30_ONE) ? Q30_ONE : cos_t[COS_N];
    s_rd  = s_cl + 31'd8192;
    c_rd  = c_cl + 31'd8192;
    s_mag = {1'b0, s_rd[30:14]};
    c_mag = {1'b0, c_rd[30:14]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q <= a_abs;
      n0_q <= angle_i[ANG_W-1];

      q1_q <= prod1[27:20];
      a1_q <= a0_q;
      n1_q <= n0_q;

      r2_q <= r0[33:0];
      n2_q <= n1_q;

      r3_q <= (r2_q >= {1'b0, TWO_PI_Q30}) ? r3_d[32:0] : r2_q[32:0];
      n3_q <= n2_q;

      if (r3_q > {1'b0, PI_Q30}) begin
        m4_q <= 32'(TWO_PI_Q30 - r3_q);
        n4_q <= !n3_q;
      end else begin
        m4_q <= r3_q[31:0];
        n4_q <= n3_q;
      end

      if (m4_q > {1'b0, HALF_PI_Q30}) begin
        u5_q  <= 31'(PI_Q30 - m4_q);
        cn5_q <= 1'b1;
      end else begin
        u5_q  <= m4_q[30:0];
        cn5_q <= 1'b0;
      end
      sn5_q <= n4_q;

      z6_q  <= zp[61:30];
      u6_q  <= u5_q;
      sg6_q <= {sn5_q, cn5_q};

      u_dl_q[0]  <= u6_q;
      for (int i = 1; i < SinDl; i++) u_dl_q[i] <= u_dl_q[i-1];
      sg_dl_q[0] <= sg6_q;
      for (int i = 1; i < CosDl; i++) sg_dl_q[i] <= sg_dl_q[i-1];
      sm_dl_q[0] <= sp[60:30];
      for (int i = 1; i <= SinPad; i++) sm_dl_q[i] <= sm_dl_q[i-1];

      sin_q <= sg_dl_q[CosDl-1][1] ? -$signed(s_mag) : $signed(s_mag);
      cos_q <= sg_dl_q[CosDl-1][0] ? -$signed(c_mag) : $signed(c_mag);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

@@ design/dtet_energy.sv @@
// ----------------------------------------------------------------------------
// dtet_energy
// Energy and slope datapath: trig products, coefficient products, adder
// tree and Q16 rounding, six stages.
// ----------------------------------------------------------------------------
module dtet_energy
  import dtet_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [TRIG_W-1:0]          sin_i,
  input  logic signed [TRIG_W-1:0]          cos_i,
  input  logic [NCOEF-1:0][COEF_W-1:0]      coef_i,
  output logic signed [OUT_W-1:0]           energy_o,
  output logic signed [OUT_W-1:0]           energy_slope_o
);

  logic signed [TRIG_W-1:0] s1_q, c1_q, s2_q, c2_q;
  logic [NCOEF-1:0][COEF_W-1:0] k1_q, k2_q;
  logic signed [35:0] pss_q, pcc_q, psc_q;
  logic signed [TRIG_W-1:0] ss2_q, cc2_q, sc2_q, dcs2_q;
  logic signed [32:0] d34_q;
  logic signed [COEF_W-1:0] c0_3_q;
  logic signed [49:0] pe1_q, pe2_q, pe3_q, pe4_q, pe5_q, pd1_q, pd2_q, pd4_q;
  logic signed [50:0] pd3_q;
  logic signed [55:0] ea_q, eb_q, da_q, db_q, e_q, d_q;
  logic signed [OUT_W-1:0] en_q, sl_q;

  logic signed [35:0] rss, rcc, rsc;
  logic signed [TRIG_W-1:0] ss, cc;
  logic signed [55:0] er, dr;

  always_comb begin
    rss = pss_q + 36'sd32768;
    rcc = pcc_q + 36'sd32768;
    rsc = psc_q + 36'sd32768;
    ss  = rss[33:16];
    cc  = rcc[33:16];
    er  = e_q + 56'sd32768;
    dr  = d_q + 56'sd32768;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pss_q <= sin_i * sin_i;
      pcc_q <= cos_i * cos_i;
      psc_q <= sin_i * cos_i;
      s1_q  <= sin_i;
      c1_q  <= cos_i;
      k1_q  <= coef_i;

      ss2_q  <= ss;
      cc2_q  <= cc;
      sc2_q  <= rsc[33:16];
      dcs2_q <= cc - ss;
      d34_q  <= 33'($signed(k1_q[3])) - 33'($signed(k1_q[4]));
      s2_q   <= s1_q;
      c2_q   <= c1_q;
      k2_q   <= k1_q;

      pe1_q  <= $signed(k2_q[1]) * s2_q;
      pe2_q  <= $signed(k2_q[2]) * c2_q;
      pe3_q  <= $signed(k2_q[3]) * ss2_q;
      pe4_q  <= $signed(k2_q[4]) * cc2_q;
      pe5_q  <= $signed(k2_q[5]) * sc2_q;
      pd1_q  <= $signed(k2_q[1]) * c2_q;
      pd2_q  <= $signed(k2_q[2]) * s2_q;
      pd3_q  <= d34_q * sc2_q;
      pd4_q  <= $signed(k2_q[5]) * dcs2_q;
      c0_3_q <= $signed(k2_q[0]);

      ea_q <= (56'(c0_3_q) <<< 16) + 56'(pe1_q) + 56'(pe2_q);
      eb_q <= 56'(pe3_q) + 56'(pe4_q) + 56'(pe5_q);
      da_q <= 56'(pd1_q) - 56'(pd2_q);
      db_q <= (56'(pd3_q) <<< 1) + 56'(pd4_q);

      e_q <= ea_q + eb_q;
      d_q <= da_q + db_q;

      en_q <= er[55:16];
      sl_q <= dr[55:16];
    end
  end

  assign energy_o       = en_q;
  assign energy_slope_o = sl_q;

endmodule

@@ bench/tb_dihedral_trig_energy_term_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dihedral_trig_energy_term_unit
// Drives coefficient loads and angle evaluations with random handshake gaps
// and checks energy and slope against a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_dihedral_trig_energy_term_unit;
  import dtet_pkg::*;

  localparam int NTYPES   = 16;
  localparam int FRAC     = 13;
  localparam int DRAIN    = 60;
  localparam int WDOG_MAX = 4000;

  typedef struct {
    dtet_cmd_e       cmd;
    logic [3:0]      ptype;
    logic [2:0]      slot;
    logic [31:0]     value;
    logic [15:0]     angle;
    bit              has_exp;
    logic [39:0]     e_exp;
    logic [39:0]     d_exp;
  } request_t;

  typedef struct {
    logic [39:0] e;
    logic [39:0] d;
  } term_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = 1'b0;
  logic [3:0]  pair_type_i = '0;
  logic [2:0]  coeff_slot_i = '0;
  logic signed [31:0] coeff_value_i = '0;
  logic signed [15:0] angle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [39:0] energy_o;
  logic signed [39:0] energy_slope_o;

  always #4 clk_i = ~clk_i;

  dihedral_trig_energy_term_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .pair_type_i,
    .coeff_slot_i, .coeff_value_i, .angle_i, .out_valid_o, .out_stall_i,
    .energy_o, .energy_slope_o
  );

  logic signed [31:0] coeffs [NTYPES*6];
  bit                 loaded [NTYPES];
  term_t              pending_terms [$];
  request_t           table_rows [$];
  int                 errors = 0;
  int                 idle_count = 0;
  bit                 no_idle = 1'b0;

  function automatic longint round16(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint sat40(longint v);
    if (v > 64'sd549755813887) return 64'sd549755813887;
    if (v < -64'sd549755813888) return -64'sd549755813888;
    return v;
  endfunction

  function automatic void trig_q16(logic signed [15:0] ang, output longint s, output longint c);
    longint x, r, y, u, z, t, sv, cv;
    bit cneg;
    longint sd [5];
    longint cd [6];
    sd = '{110, 72, 42, 20, 6};
    cd = '{132, 90, 56, 30, 12, 2};
    x = longint'(ang) * (longint'(1) << (30 - FRAC));
    r = x % 64'sd6746518852;
    cneg = 1'b0;
    if (r > 64'sd3373259426) r -= 64'sd6746518852;
    else if (r < -64'sd3373259426) r += 64'sd6746518852;
    if (r > 64'sd1686629713) begin
      y = 64'sd3373259426 - r;
      cneg = 1'b1;
    end else if (r < -64'sd1686629713) begin
      y = -64'sd3373259426 - r;
      cneg = 1'b1;
    end else begin
      y = r;
    end
    u = (y < 0) ? -y : y;
    z = (u * u) >>> 30;
    t = 64'sd1 << 30;
    for (int i = 0; i < 5; i++) t = (64'sd1 << 30) - ((z * t) / (64'sd1 << 30)) / sd[i];
    sv = (u * t) / (64'sd1 << 30);
    t = 64'sd1 << 30;
    for (int i = 0; i < 6; i++) t = (64'sd1 << 30) - ((z * t) / (64'sd1 << 30)) / cd[i];
    cv = t;
    if (sv < 0) sv = 0;
    if (sv > (64'sd1 << 30)) sv = 64'sd1 << 30;
    if (cv < 0) cv = 0;
    if (cv > (64'sd1 << 30)) cv = 64'sd1 << 30;
    sv = (sv + 8192) >>> 14;
    cv = (cv + 8192) >>> 14;
    s = (y < 0) ? -sv : sv;
    c = cneg ? -cv : cv;
  endfunction

  function automatic term_t energy_term(logic [3:0] ptype, logic signed [15:0] ang);
    longint cf [6];
    longint s, c, ss, cc, sc, e, d;
    term_t res;
    for (int k = 0; k < 6; k++)
      cf[k] = (ptype < NTYPES) ? longint'(coeffs[ptype*6+k]) : 0;
    trig_q16(ang, s, c);
    ss = round16(s * s, 16);
    cc = round16(c * c, 16);
    sc = round16(s * c, 16);
    e = cf[0] * 65536 + cf[1] * s + cf[2] * c + cf[3] * ss + cf[4] * cc + cf[5] * sc;
    d = cf[1] * c - cf[2] * s + 2 * cf[3] * sc - 2 * cf[4] * sc + cf[5] * (cc - ss);
    res.e = 40'(sat40(round16(e, 16)));
    res.d = 40'(sat40(round16(d, 16)));
    return res;
  endfunction

  function automatic void apply_request(request_t rq);
    term_t tr;
    if (rq.cmd == CMD_LOAD) begin
      if (rq.slot < 6) begin
        coeffs[rq.ptype*6+rq.slot] = rq.value;
        if (rq.slot == 5) loaded[rq.ptype] = 1'b1;
      end
    end else begin
      tr = energy_term(rq.ptype, rq.angle);
      if (rq.has_exp && (tr.e !== rq.e_exp || tr.d !== rq.d_exp)) begin
        $display("%0t predictor disagrees with row: expected %h %h actual %h %h",
                 $time, rq.e_exp, rq.d_exp, tr.e, tr.d);
        errors++;
      end
      if (rq.has_exp) begin
        tr.e = rq.e_exp;
        tr.d = rq.d_exp;
      end
      pending_terms.push_back(tr);
    end
  endfunction

  function automatic request_t load_row(int pt, int sl, logic [31:0] v);
    request_t rq;
    rq = '{CMD_LOAD, 4'(pt), 3'(sl), v, 16'h0, 1'b0, 40'h0, 40'h0};
    return rq;
  endfunction

  function automatic request_t eval_row(int pt, logic [15:0] a, bit he,
                                        logic [39:0] ee, logic [39:0] de);
    request_t rq;
    rq = '{CMD_EVAL, 4'(pt), 3'($urandom), $urandom, a, he, ee, de};
    return rq;
  endfunction

  task automatic send(request_t rq);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= rq.cmd;
    pair_type_i   <= rq.ptype;
    coeff_slot_i  <= rq.slot;
    coeff_value_i <= rq.value;
    angle_i       <= rq.angle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_request(rq);
  endtask

  task automatic load_type(int pt, bit extreme);
    logic [31:0] v;
    for (int sl = 0; sl < 6; sl++) begin
      case ($urandom_range(0, 3))
        0: v = extreme ? ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000) : $urandom;
        1: v = $urandom;
        default: v = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
      send(load_row(pt, sl, v));
    end
  endtask

  always @(posedge clk_i) begin
    term_t tr;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_terms.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h %h",
                   $time, energy_o, energy_slope_o);
          errors++;
        end else begin
          tr = pending_terms.pop_front();
          if (energy_o !== tr.e) begin
            $display("%0t energy: expected %h actual %h", $time, tr.e, energy_o);
            errors++;
          end
          if (energy_slope_o !== tr.d) begin
            $display("%0t energy_slope: expected %h actual %h", $time, tr.d, energy_slope_o);
            errors++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count > WDOG_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stall_gen
    int len;
    forever begin
      @(posedge clk_i);
      if (!no_idle && $urandom_range(0, 6) == 0) begin
        len = $urandom_range(1, 8);
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    request_t rq;
    int pt, n;
    logic [15:0] a;
    for (int i = 0; i < NTYPES*6; i++) coeffs[i] = '0;
    for (int i = 0; i < NTYPES; i++) loaded[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: C0 = 1.0 only on type 0, others zero; out-of-range slot loads are dropped
    for (int sl = 0; sl < 6; sl++)
      table_rows.push_back(load_row(0, sl, sl == 0 ? 32'h0001_0000 : 32'h0));
    table_rows.push_back(load_row(0, 6, 32'h7fff_ffff));
    table_rows.push_back(load_row(0, 7, 32'h8000_0000));
    table_rows.push_back(eval_row(0, 16'h0000, 1, 40'h0001_0000, 40'h0));
    table_rows.push_back(eval_row(0, 16'sd25736, 1, 40'h0001_0000, 40'h0));
    table_rows.push_back(eval_row(0, -16'sd25736, 1, 40'h0001_0000, 40'h0));
    table_rows.push_back(eval_row(0, 16'h7fff, 1, 40'h0001_0000, 40'h0));
    table_rows.push_back(eval_row(0, 16'h8000, 1, 40'h0001_0000, 40'h0));
    // type 1 gets extreme coefficients
    for (int sl = 0; sl < 6; sl++)
      table_rows.push_back(load_row(1, sl, sl[0] ? 32'h8000_0000 : 32'h7fff_ffff));
    table_rows.push_back(eval_row(1, 16'h0000, 0, 40'h0, 40'h0));
    table_rows.push_back(eval_row(1, 16'sd12868, 0, 40'h0, 40'h0));
    table_rows.push_back(eval_row(1, 16'h8000, 0, 40'h0, 40'h0));
    table_rows.push_back(eval_row(1, 16'hffff, 0, 40'h0, 40'h0));
    foreach (table_rows[i]) send(table_rows[i]);

    // hold until every pending result has drained
    in_valid_i <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);

    n = 0;
    while (n < 1700) begin
      if (n > 1450) no_idle = 1'b1;
      pt = $urandom_range(0, NTYPES - 1);
      if (!loaded[pt] || $urandom_range(0, 30) == 0) begin
        load_type(pt, $urandom_range(0, 3) == 0);
        n += 6;
      end else if ($urandom_range(0, 15) == 0) begin
        rq = load_row(pt, $urandom_range(0, 7), $urandom);
        rq.value = $urandom;
        send(rq);
        n++;
      end else begin
        case ($urandom_range(0, 5))
          0: a = 16'($urandom);
          1: a = $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
          default: a = 16'($signed($urandom_range(0, 51472)) - 25736);
        endcase
        send(eval_row(pt, a, 0, 40'h0, 40'h0));
        n++;
      end
    end
    in_valid_i <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
